[rtl/free_list_handle_pool_defines.svh]
// Assertion macros shared by the pool modules.
`ifndef FREE_LIST_HANDLE_POOL_DEFINES_SVH
`define FREE_LIST_HANDLE_POOL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FLHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/flhp_pkg.sv]
`default_nettype none

package flhp_pkg;

  localparam int unsigned POOL_DEPTH = 256;
  localparam int unsigned SLOT_W     = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CAP_W      = 9;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [1:0] {
    FUNC_INIT   = 2'd0,
    FUNC_ALLOC  = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_LOOKUP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_FULL         = 2'd1,
    STATUS_INVALID      = 2'd2,
    STATUS_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'd0,
    CFG_PREFIX   = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    func_e                     func;
    logic [DATA_W-1:0]         global_handle;
    logic signed [DATA_W-1:0]  first_payload;
    logic signed [DATA_W-1:0]  second_payload;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  allocated_handle;
    logic signed [DATA_W-1:0]  first_out;
    logic signed [DATA_W-1:0]  second_out;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic sweep;
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic init_empty;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

[rtl/free_list_handle_pool.sv]
// Handle pool of 256 slots, each holding two 32-bit payloads, kept on a linked free list.
// Issue an operation by raising start_i with req_i while busy_o is low; the result appears
// on res_o for exactly one cycle with done_o high and must be captured then, since the
// receiver cannot stall. Allocate, free and lookup read the slot memories when accepted,
// then write back into them, and a new operation may start in the cycle the result is
// shown. Init rewrites one link entry per cycle for each slot up to the capacity, with
// the capacity saturated at 256. Registers: index 0 sets the capacity applied at the next
// init, index 1 the prefix ORed into allocated handles; write them only while idle. Until
// the first init the pool has no slots: allocate reports full, free and lookup invalid.
`default_nettype none

module free_list_handle_pool (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  flhp_pkg::req_t                      req_i,
  output logic                                done_o,
  output flhp_pkg::res_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [flhp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [flhp_pkg::DATA_W-1:0]         cfg_data_i
);

  flhp_pkg::cmd_t  cmd;
  flhp_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  flhp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (req_i.func),
    .stat_i  (stat),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  flhp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (flhp_pkg::cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

[rtl/flhp_ctrl.sv]
`default_nettype none
`include "free_list_handle_pool_defines.svh"

module flhp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  flhp_pkg::func_e       func_i,
  input  flhp_pkg::stat_t       stat_i,
  output logic                  busy_o,
  output flhp_pkg::cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_INIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.sweep  = 1'b0;
    cmd_o.exec   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          // an empty init skips the link sweep
          if (func_i == flhp_pkg::FUNC_INIT && !stat_i.init_empty) begin
            state_d = ST_INIT;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FLHP_ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni, accept, busy_o, "accepted transfer did not raise busy")
  `FLHP_ASSERT_NEXT(a_sweep_ends_in_exec, clk_i, rst_ni, (state_q == ST_INIT) && stat_i.sweep_last, state_q == ST_EXEC, "sweep end did not reach exec")
  `FLHP_ASSERT_NEXT(a_exec_one_cycle, clk_i, rst_ni, state_q == ST_EXEC, state_q == ST_IDLE, "exec lasted more than one cycle")

endmodule

`default_nettype wire

[rtl/flhp_datapath.sv]
`default_nettype none
`include "free_list_handle_pool_defines.svh"

module flhp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  flhp_pkg::req_t                      req_i,
  input  flhp_pkg::cmd_t                      cmd_i,
  output flhp_pkg::stat_t                     stat_o,
  input  logic                                cfg_we_i,
  input  flhp_pkg::cfg_idx_e                  cfg_index_i,
  input  logic [flhp_pkg::DATA_W-1:0]         cfg_data_i,
  output logic                                done_o,
  output flhp_pkg::res_t                      res_o
);

  typedef struct packed {
    logic           used;
    flhp_pkg::cnt_t next;
  } link_t;

  typedef struct packed {
    logic [flhp_pkg::DATA_W-1:0] first;
    logic [flhp_pkg::DATA_W-1:0] second;
  } pay_t;

  // Configuration registers
  logic [flhp_pkg::CAP_W-1:0]  capacity_q;
  logic [flhp_pkg::DATA_W-1:0] prefix_q;

  // Pool state
  flhp_pkg::cnt_t free_head_q, free_head_d;
  flhp_pkg::cnt_t pool_size_q, pool_size_d;

  // Latched request
  flhp_pkg::func_e             req_func_q;
  flhp_pkg::idx_t              req_idx_q;
  pay_t                        req_pay_q;
  flhp_pkg::cnt_t              req_cap_q;
  flhp_pkg::cnt_t              sweep_ptr_q;

  // Memories
  link_t link_mem [flhp_pkg::POOL_DEPTH];
  pay_t  pay_mem  [flhp_pkg::POOL_DEPTH];
  link_t link_rd_q;
  pay_t  pay_rd_q;

  logic            link_we, pay_we;
  flhp_pkg::slot_t link_waddr, pay_waddr, rd_addr;
  link_t           link_wdata;
  pay_t            pay_wdata;

  flhp_pkg::cnt_t  cap_sat;
  flhp_pkg::idx_t  in_idx;
  logic            idx_in_range;
  flhp_pkg::res_t  res_d;
  flhp_pkg::res_t  res_q;
  logic            done_q;

  assign cap_sat = (32'(capacity_q) > flhp_pkg::POOL_DEPTH) ?
                   flhp_pkg::CNT_W'(flhp_pkg::POOL_DEPTH) : flhp_pkg::CNT_W'(capacity_q);

  assign in_idx = req_i.global_handle[flhp_pkg::IDX_W-1:0];

  // Read at the head for allocate, at the handle's slot otherwise.
  assign rd_addr = (req_i.func == flhp_pkg::FUNC_ALLOC) ?
                   free_head_q[flhp_pkg::SLOT_W-1:0] : in_idx[flhp_pkg::SLOT_W-1:0];

  assign stat_o.init_empty = (cap_sat == '0);
  assign stat_o.sweep_last = ((sweep_ptr_q + flhp_pkg::CNT_W'(1)) == req_cap_q);

  assign idx_in_range = (req_idx_q < flhp_pkg::IDX_W'(pool_size_q));

  always_comb begin
    free_head_d            = free_head_q;
    pool_size_d            = pool_size_q;
    link_we                = 1'b0;
    link_waddr             = sweep_ptr_q[flhp_pkg::SLOT_W-1:0];
    link_wdata.used        = 1'b0;
    link_wdata.next        = sweep_ptr_q + flhp_pkg::CNT_W'(1);
    pay_we                 = 1'b0;
    pay_waddr              = free_head_q[flhp_pkg::SLOT_W-1:0];
    pay_wdata              = req_pay_q;
    res_d.status           = flhp_pkg::STATUS_OK;
    res_d.allocated_handle = '1;
    res_d.first_out        = '1;
    res_d.second_out       = '1;

    if (cmd_i.sweep) begin
      link_we = 1'b1;
    end

    if (cmd_i.exec) begin
      case (req_func_q)
        flhp_pkg::FUNC_INIT: begin
          pool_size_d = req_cap_q;
          free_head_d = '0;
        end
        flhp_pkg::FUNC_ALLOC: begin
          if (free_head_q >= pool_size_q) begin
            res_d.status = flhp_pkg::STATUS_FULL;
          end else begin
            // pop the head and mark it used
            link_we                = 1'b1;
            link_waddr             = free_head_q[flhp_pkg::SLOT_W-1:0];
            link_wdata.used        = 1'b1;
            link_wdata.next        = link_rd_q.next;
            pay_we                 = 1'b1;
            free_head_d            = link_rd_q.next;
            res_d.allocated_handle = prefix_q | flhp_pkg::DATA_W'(free_head_q);
          end
        end
        flhp_pkg::FUNC_FREE: begin
          if (!idx_in_range) begin
            res_d.status = flhp_pkg::STATUS_INVALID;
          end else if (!link_rd_q.used) begin
            res_d.status = flhp_pkg::STATUS_ALREADY_FREE;
          end else begin
            // push the slot back and poison its payload
            link_we         = 1'b1;
            link_waddr      = req_idx_q[flhp_pkg::SLOT_W-1:0];
            link_wdata.used = 1'b0;
            link_wdata.next = free_head_q;
            pay_we          = 1'b1;
            pay_waddr       = req_idx_q[flhp_pkg::SLOT_W-1:0];
            pay_wdata       = '1;
            free_head_d     = req_idx_q[flhp_pkg::CNT_W-1:0];
          end
        end
        flhp_pkg::FUNC_LOOKUP: begin
          if (!idx_in_range) begin
            res_d.status = flhp_pkg::STATUS_INVALID;
          end else begin
            res_d.first_out  = pay_rd_q.first;
            res_d.second_out = pay_rd_q.second;
          end
        end
        default: begin
          res_d.status = flhp_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    pay_rd_q <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_func_q       <= req_i.func;
      req_idx_q        <= in_idx;
      req_pay_q.first  <= req_i.first_payload;
      req_pay_q.second <= req_i.second_payload;
      req_cap_q        <= cap_sat;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= flhp_pkg::CAP_W'(flhp_pkg::POOL_DEPTH);
      prefix_q    <= '0;
      free_head_q <= '0;
      pool_size_q <= '0;
      sweep_ptr_q <= '0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          flhp_pkg::CFG_CAPACITY: capacity_q <= cfg_data_i[flhp_pkg::CAP_W-1:0];
          flhp_pkg::CFG_PREFIX:   prefix_q   <= cfg_data_i;
          default:                prefix_q   <= prefix_q;
        endcase
      end
      free_head_q <= free_head_d;
      pool_size_q <= pool_size_d;
      if (cmd_i.accept) begin
        sweep_ptr_q <= '0;
      end else if (cmd_i.sweep) begin
        sweep_ptr_q <= sweep_ptr_q + flhp_pkg::CNT_W'(1);
      end
      done_q <= cmd_i.exec;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `FLHP_ASSERT_SAME(a_head_within_pool, clk_i, rst_ni, 1'b1, free_head_q <= pool_size_q, "free list head beyond pool size")
  `FLHP_ASSERT_SAME(a_error_clears_fields, clk_i, rst_ni, done_q && (res_q.status != flhp_pkg::STATUS_OK), (res_q.allocated_handle == '1) && (res_q.first_out == '1) && (res_q.second_out == '1), "error result carries data")

endmodule

`default_nettype wire
